>>> hdl/pixel_grid_darken_assert.svh
// Assertion helpers shared by the pgd modules.
`ifndef PIXEL_GRID_DARKEN_ASSERT_SVH
`define PIXEL_GRID_DARKEN_ASSERT_SVH

`ifndef SYNTHESIS

// cond must never hold outside reset
`define PGD_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("pgd: forbidden condition seen");

// a in this cycle implies c in the same cycle
`define PGD_ASSERT_IMPLY(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("pgd: implication failed");

// a in this cycle implies c in the next cycle
`define PGD_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("pgd: next-cycle implication failed");

`else

`define PGD_ASSERT_NEVER(lbl, clk, rst, cond)
`define PGD_ASSERT_IMPLY(lbl, clk, rst, a, c)
`define PGD_ASSERT_NEXT(lbl, clk, rst, a, c)

`endif

`endif

>>> hdl/pgd_pkg.sv
package pgd_pkg;

  localparam int COORD_BITS = 12;
  localparam int SPACING_W  = 12;
  localparam int DARK_W     = 8;
  localparam int CHAN_W     = 8;
  localparam int COV_W      = 8;
  localparam int NUM_CHAN   = 3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_SPACING = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DARKNESS     = 1'd1;

  localparam logic [SPACING_W-1:0] SPACING_RESET  = 12'd8;
  localparam logic [DARK_W-1:0]    DARKNESS_RESET = 8'd0;

  localparam int QUEUE_DEPTH_DEF  = 4;
  localparam int RESULT_DEPTH_DEF = 4;

  typedef struct packed {
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [CHAN_W-1:0]     red_in;
    logic [CHAN_W-1:0]     green_in;
    logic [CHAN_W-1:0]     blue_in;
    logic [COV_W-1:0]      coverage;
    logic                  masked;
  } pgd_pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              on_grid;
  } pgd_result_t;

  // classified pixel handed from front to back
  typedef struct packed {
    logic [NUM_CHAN-1:0][CHAN_W-1:0] chan;   // 0 red, 1 green, 2 blue
    logic [COV_W-1:0]                coverage;
    logic                            masked;
    logic                            on_grid;
    logic                            active;  // channels get shaded
  } pgd_job_t;

  // live configuration seen by both halves
  typedef struct packed {
    logic [SPACING_W-1:0] spacing;  // already clamped to at least one
    logic [DARK_W-1:0]    factor;   // 255 - darkness
  } pgd_cfg_t;

  // one restoring-division step: shift in a bit, subtract spacing if it fits
  function automatic logic [SPACING_W-1:0] rem_step(input logic [SPACING_W-1:0] rem,
                                                    input logic din,
                                                    input logic [SPACING_W-1:0] sp);
    logic [SPACING_W:0] t;
    t = {rem, din};
    if (t >= {1'b0, sp}) begin
      t = t - {1'b0, sp};
    end
    return t[SPACING_W-1:0];
  endfunction

endpackage

>>> hdl/pgd_fifo.sv
`include "pixel_grid_darken_assert.svh"

module pgd_fifo import pgd_pkg::*; #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == LAST_PTR) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  `PGD_ASSERT_NEVER(a_fifo_count, clk, rst, count > FULL_CNT)
  `PGD_ASSERT_NEXT(a_fifo_fill, clk, rst, do_wr && !do_rd, !empty)

endmodule

>>> hdl/pgd_front.sv
`include "pixel_grid_darken_assert.svh"

module pgd_front import pgd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  pgd_cfg_t   cfg,
  input  logic       push,
  output logic       full,
  input  pgd_pixel_t pixel,
  output logic       q_wr,
  output pgd_job_t   q_data,
  input  logic       q_full
);

  localparam int LAST = COORD_BITS - 1;

  // one coordinate bit per stage, x and y side by side
  logic [COORD_BITS-1:0] valid;
  pgd_pixel_t            pix   [COORD_BITS];
  logic [SPACING_W-1:0]  rem_x [COORD_BITS];
  logic [SPACING_W-1:0]  rem_y [COORD_BITS];
  logic                  advance;
  logic                  grid;

  // whole pipe moves together; it only holds when the queue backs up
  assign advance = !valid[LAST] || !q_full;
  assign full    = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (advance) begin
      valid <= {valid[COORD_BITS-2:0], push};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pix[0]   <= pixel;
      rem_x[0] <= rem_step('0, pixel.pos_x[LAST], cfg.spacing);
      rem_y[0] <= rem_step('0, pixel.pos_y[LAST], cfg.spacing);
      for (int k = 1; k < COORD_BITS; k++) begin
        pix[k]   <= pix[k-1];
        rem_x[k] <= rem_step(rem_x[k-1], pix[k-1].pos_x[LAST-k], cfg.spacing);
        rem_y[k] <= rem_step(rem_y[k-1], pix[k-1].pos_y[LAST-k], cfg.spacing);
      end
    end
  end

  assign grid = (rem_x[LAST] == '0) || (rem_y[LAST] == '0);

  always_comb begin
    q_data.chan[0]  = pix[LAST].red_in;
    q_data.chan[1]  = pix[LAST].green_in;
    q_data.chan[2]  = pix[LAST].blue_in;
    q_data.coverage = pix[LAST].coverage;
    q_data.masked   = pix[LAST].masked;
    q_data.on_grid  = grid;
    // masked with zero coverage passes through
    q_data.active   = grid && !(pix[LAST].masked && (pix[LAST].coverage == '0));
  end

  assign q_wr = valid[LAST] && !q_full;

  `PGD_ASSERT_NEXT(a_front_hold, clk, rst, valid[LAST] && !advance, valid[LAST])

endmodule

>>> hdl/pgd_back.sv
`include "pixel_grid_darken_assert.svh"

module pgd_back import pgd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  pgd_cfg_t    cfg,
  input  logic        q_empty,
  input  pgd_job_t    q_data,
  output logic        q_rd,
  output logic        r_wr,
  output pgd_result_t r_data,
  input  logic        r_full
);

  localparam int PROD_W = 2 * CHAN_W;

  logic                            advance;
  logic                            s1_valid, s2_valid;
  pgd_job_t                        s1_job, s2_job;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] s1_n, s2_n;
  logic [NUM_CHAN-1:0][PROD_W-1:0] s2_dprod;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] res;

  assign advance = !s2_valid || !r_full;
  assign q_rd    = advance && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= !q_empty;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [PROD_W-1:0] p;
    if (advance) begin
      s1_job <= q_data;
      s2_job <= s1_job;
      s2_n   <= s1_n;
      for (int c = 0; c < NUM_CHAN; c++) begin
        // n = c * factor / 256
        p        = PROD_W'(q_data.chan[c]) * PROD_W'(cfg.factor);
        s1_n[c]  <= p[PROD_W-1:CHAN_W];
        // distance toward n, weighted by coverage
        s2_dprod[c] <= PROD_W'(s1_job.chan[c] - s1_n[c]) * PROD_W'(s1_job.coverage);
      end
    end
  end

  always_comb begin
    logic [PROD_W-1:0] up;
    for (int c = 0; c < NUM_CHAN; c++) begin
      up = s2_dprod[c] + PROD_W'(8'd255);
      if (!s2_job.active) begin
        res[c] = s2_job.chan[c];
      end else if (s2_job.masked) begin
        res[c] = s2_job.chan[c] - up[PROD_W-1:CHAN_W];
      end else begin
        res[c] = s2_n[c];
      end
    end
  end

  assign r_wr             = s2_valid && !r_full;
  assign r_data.red_out   = res[0];
  assign r_data.green_out = res[1];
  assign r_data.blue_out  = res[2];
  assign r_data.on_grid   = s2_job.on_grid;

  // shading only ever darkens
  `PGD_ASSERT_IMPLY(a_back_darker, clk, rst, s2_valid, res[0] <= s2_job.chan[0])

endmodule

>>> hdl/pixel_grid_darken.sv
// Path: an accepted pixel passes the COORD_BITS front stages, the job queue,
//   back stages s1 and s2 and the result queue before it reaches the result ports.
// Throughput: one pixel per clock while results are popped; the grid test and the
//   shading are both fully pipelined, and the queues only add slack.
// Reset (rst, synchronous): clears the pipes and both queues,
//   grid_spacing to 8, darkness to 0.
module pixel_grid_darken import pgd_pkg::*; #(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int RESULT_DEPTH = RESULT_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // pixel side, queue style
  input  logic                  push,
  output logic                  full,
  input  pgd_pixel_t            pixel,
  // result side, queue style
  output logic                  empty,
  input  logic                  pop,
  output pgd_result_t           result,
  // register writes
  input  logic                  cfg_wr,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Structure:
  //   front : COORD_BITS-stage restoring remainder pipe on pos_x and pos_y
  //           (one quotient bit per stage), then on-grid / pass-through tag
  //   queue : classified beats, so the front keeps taking pixels while the
  //           back is blocked by a full result queue
  //   back  : stage 1 multiplies each channel by (255 - darkness),
  //           stage 2 multiplies the remaining distance by coverage,
  //           final subtract and select go into the result queue
  // Each half stalls as a whole only when the queue after it is full.

  logic [SPACING_W-1:0] grid_spacing;
  logic [DARK_W-1:0]    darkness;
  pgd_cfg_t             cfg;

  logic        q_wr, q_full, q_rd, q_empty;
  pgd_job_t    q_wdata, q_rdata;
  logic        r_wr, r_full;
  pgd_result_t r_wdata;

  // config registers; only write them while no pixel is in flight (the block does not enforce this)
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_spacing <= SPACING_RESET;
      darkness     <= DARKNESS_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_GRID_SPACING: grid_spacing <= cfg_data[SPACING_W-1:0];
        REG_DARKNESS:     darkness     <= cfg_data[DARK_W-1:0];
        default: ;
      endcase
    end
  end

  // zero spacing behaves as one: every pixel on the grid
  assign cfg.spacing = (grid_spacing == '0) ? SPACING_W'(1) : grid_spacing;
  assign cfg.factor  = ~darkness;

  pgd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .push   (push),
    .full   (full),
    .pixel  (pixel),
    .q_wr   (q_wr),
    .q_data (q_wdata),
    .q_full (q_full)
  );

  pgd_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH ($bits(pgd_job_t))
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  pgd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_rd    (q_rd),
    .r_wr    (r_wr),
    .r_data  (r_wdata),
    .r_full  (r_full)
  );

  // result queue: a finished beat waits here without blocking the back
  pgd_fifo #(
    .DEPTH (RESULT_DEPTH),
    .WIDTH ($bits(pgd_result_t))
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (r_wr),
    .wdata (r_wdata),
    .full  (r_full),
    .rd    (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule
